### design/tile_map_pixel_lookup_macros.svh
// Assertion macros used by the checker of the tile map pixel lookup.
`ifndef TILE_MAP_PIXEL_LOOKUP_MACROS_SVH
`define TILE_MAP_PIXEL_LOOKUP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TMPL_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tile map lookup check failed");

// An implication within the same cycle.
`define TMPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile map lookup check failed");

// An implication whose consequence is checked after the delay given by n.
`define TMPL_ASSERT_LAT(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("tile map lookup latency check failed");

`endif

### design/tmpl_pkg.sv
// Shared constants, codes and types of the tile map pixel lookup.
`timescale 1ns / 1ps
package tmpl_pkg;

  localparam int MAP_ENTRIES       = 4096;
  localparam int PIXEL_STORE_DEPTH = 65536;
  localparam int PALETTE_DEPTH     = 256;

  localparam int MAP_AW = $clog2(MAP_ENTRIES);
  localparam int PIX_AW = $clog2(PIXEL_STORE_DEPTH);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  // Nonnegative coordinates carry 15 magnitude bits; one divider stage per bit.
  localparam int COORD_W   = 15;
  localparam int TS_W      = 9;
  localparam int TPR_W     = 13;
  localparam int AREA_W    = 17;
  localparam int ROW_W     = COORD_W + TPR_W;
  localparam int MAP_OFF_W = ROW_W + 1;
  localparam int IN_OFF_W  = 2 * TS_W + 1;
  localparam int TPROD_W   = 16 + AREA_W;
  localparam int PIX_OFF_W = TPROD_W + 1;
  localparam int LATENCY   = COORD_W + 7;

  typedef enum logic [1:0] {
    MODE_QUERY   = 2'd0,
    MODE_MAP     = 2'd1,
    MODE_PIXEL   = 2'd2,
    MODE_PALETTE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FAULT   = 2'd2
  } status_t;

  localparam logic [2:0] REG_MAP_WIDTH     = 3'd0;
  localparam logic [2:0] REG_MAP_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_TILE_SIZE     = 3'd2;
  localparam logic [2:0] REG_TILES_PER_ROW = 3'd3;
  localparam logic [2:0] REG_TILE_AREA     = 3'd4;

  typedef struct packed {
    logic [15:0]       map_width;
    logic [15:0]       map_height;
    logic [TS_W-1:0]   tile_edge;
    logic [TPR_W-1:0]  tiles_per_row;
    logic [AREA_W-1:0] tile_area;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    mode_t              mode;
    status_t            status;
    logic [15:0]        wr_idx;
    logic [31:0]        wr_data;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [TS_W-1:0]    rx;
    logic [TS_W-1:0]    ry;
  } dstage_t;

endpackage

### design/tile_map_pixel_lookup.sv
// Top level of the tile map pixel lookup.
`timescale 1ns / 1ps
// A transaction is taken on every cycle that start is high and busy is low;
// busy is high only during reset, so one transaction per clock is sustained.
// A query (mode 0) produces one result on color and status, marked by a
// one-cycle done strobe; store writes (modes 1 to 3) produce no result. A
// query passes through the input register, the 15-stage restoring divider
// that splits the pixel position by the tile size, and six stages for the
// offset multiplies, the three store reads and the result register. Results
// leave in the order the transactions arrived, and the receiver cannot hold
// them off. The user must write configuration through cfg_valid/cfg_ready
// only while no transaction is in flight; the block does not enforce it.
module tile_map_pixel_lookup (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        write_index,
  input  logic [31:0]        write_data,
  output logic               done,
  output logic [31:0]        color,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tmpl_pkg::*;

  cfg_t    cfg;
  dstage_t div_out;

  assign busy = rst;

  tmpl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  tmpl_div u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .mode        (mode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .write_index (write_index),
    .write_data  (write_data),
    .cfg         (cfg),
    .dout        (div_out)
  );

  tmpl_fetch u_fetch (
    .clk    (clk),
    .rst    (rst),
    .din    (div_out),
    .cfg    (cfg),
    .done   (done),
    .color  (color),
    .status (status)
  );

endmodule

### design/tmpl_cfg.sv
// Configuration register file of the tile map pixel lookup.
`timescale 1ns / 1ps
module tmpl_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          cfg_ready,
  output tmpl_pkg::cfg_t cfg
);
  import tmpl_pkg::*;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width     <= '0;
      cfg.map_height    <= '0;
      cfg.tile_edge     <= TS_W'(8);
      cfg.tiles_per_row <= TPR_W'(1);
      cfg.tile_area     <= AREA_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:     cfg.map_width     <= cfg_data[15:0];
        REG_MAP_HEIGHT:    cfg.map_height    <= cfg_data[15:0];
        REG_TILE_SIZE:     cfg.tile_edge     <= cfg_data[TS_W-1:0];
        REG_TILES_PER_ROW: cfg.tiles_per_row <= cfg_data[TPR_W-1:0];
        REG_TILE_AREA:     cfg.tile_area     <= cfg_data[AREA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/tmpl_div.sv
// Range check and pipelined restoring divider that splits x and y by the tile size.
`timescale 1ns / 1ps
module tmpl_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            mode,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  input  logic [15:0]           write_index,
  input  logic [31:0]           write_data,
  input  tmpl_pkg::cfg_t        cfg,
  output tmpl_pkg::dstage_t     dout
);
  import tmpl_pkg::*;

  dstage_t stage [0:COORD_W];
  dstage_t s0_next;
  logic    outside;

  function automatic dstage_t div_step(dstage_t s, logic [TS_W-1:0] ts);
    dstage_t        o;
    logic [TS_W:0]  r2x;
    logic [TS_W:0]  r2y;
    logic           bx;
    logic           by;
    o   = s;
    r2x = {s.rx, s.nx[COORD_W-1]};
    r2y = {s.ry, s.ny[COORD_W-1]};
    bx  = (r2x >= {1'b0, ts});
    by  = (r2y >= {1'b0, ts});
    if (bx) r2x = r2x - {1'b0, ts};
    if (by) r2y = r2y - {1'b0, ts};
    o.rx = r2x[TS_W-1:0];
    o.ry = r2y[TS_W-1:0];
    o.qx = {s.qx[COORD_W-2:0], bx};
    o.qy = {s.qy[COORD_W-2:0], by};
    o.nx = {s.nx[COORD_W-2:0], 1'b0};
    o.ny = {s.ny[COORD_W-2:0], 1'b0};
    return o;
  endfunction

  always_comb begin
    outside = pos_x[15] || pos_y[15] ||
              ($unsigned(pos_x) >= cfg.map_width) ||
              ($unsigned(pos_y) >= cfg.map_height);
    s0_next.valid   = in_valid;
    s0_next.mode    = mode_t'(mode);
    if (outside) begin
      s0_next.status = ST_OUTSIDE;
    end else if (cfg.tile_edge == '0) begin
      s0_next.status = ST_FAULT;
    end else begin
      s0_next.status = ST_INSIDE;
    end
    s0_next.wr_idx  = write_index;
    s0_next.wr_data = write_data;
    s0_next.nx      = pos_x[COORD_W-1:0];
    s0_next.ny      = pos_y[COORD_W-1:0];
    s0_next.qx      = '0;
    s0_next.qy      = '0;
    s0_next.rx      = '0;
    s0_next.ry      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) stage[0] <= '0;
    else stage[0] <= s0_next;
  end

  // The user must change tile size only while the pipeline is empty; unenforced.
  for (genvar k = 1; k <= COORD_W; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) stage[k] <= '0;
      else stage[k] <= div_step(stage[k-1], cfg.tile_edge);
    end
  end

  assign dout = stage[COORD_W];

endmodule

### design/tmpl_fetch.sv
// Offset arithmetic, the three store lookups and writes, and the result register.
`timescale 1ns / 1ps
module tmpl_fetch (
  input  logic              clk,
  input  logic              rst,
  input  tmpl_pkg::dstage_t din,
  input  tmpl_pkg::cfg_t    cfg,
  output logic              done,
  output logic [31:0]       color,
  output logic [1:0]        status
);
  import tmpl_pkg::*;

  typedef struct packed {
    logic        valid;
    mode_t       mode;
    status_t     status;
    logic [15:0] wr_idx;
    logic [31:0] wr_data;
  } item_t;

  logic [15:0] map_mem [MAP_ENTRIES];
  logic [7:0]  pix_mem [PIXEL_STORE_DEPTH];
  logic [31:0] pal_mem [PALETTE_DEPTH];

  item_t a_item, b_item, c_item, d_item, e_item;
  item_t b_next, d_next;

  logic [ROW_W-1:0]     a_row;
  logic [COORD_W-1:0]   a_qx;
  logic [IN_OFF_W-1:0]  a_in_off, b_in_off, c_in_off;
  logic [2*TS_W-1:0]    in_prod;
  logic [MAP_OFF_W-1:0] map_off;
  logic [15:0]          map_q;
  logic [TPROD_W-1:0]   c_tprod;
  logic [PIX_OFF_W-1:0] pix_off;
  logic [7:0]           pix_q;
  logic [31:0]          pal_q;
  logic                 map_we, pix_we, pal_we;

  // Stage one: row base of the tile map and the offset inside the tile.
  assign in_prod = din.ry * cfg.tile_edge;

  always_ff @(posedge clk) begin
    a_item.valid   <= din.valid && !rst;
    a_item.mode    <= din.mode;
    a_item.status  <= din.status;
    a_item.wr_idx  <= din.wr_idx;
    a_item.wr_data <= din.wr_data;
    a_row          <= din.qy * cfg.tiles_per_row;
    a_qx           <= din.qx;
    a_in_off       <= IN_OFF_W'(in_prod) + IN_OFF_W'(din.rx);
  end

  // Stage two: tile map access. Writes land here so later queries see them.
  always_comb begin
    map_off = MAP_OFF_W'(a_row) + MAP_OFF_W'(a_qx);
    b_next  = a_item;
    if (a_item.status == ST_INSIDE && map_off >= MAP_OFF_W'(MAP_ENTRIES)) begin
      b_next.status = ST_FAULT;
    end
    map_we = a_item.valid && a_item.mode == MODE_MAP &&
             (32'(a_item.wr_idx) < 32'(MAP_ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[MAP_AW'(32'(a_item.wr_idx))] <= a_item.wr_data[15:0];
    map_q    <= map_mem[MAP_AW'(map_off)];
    b_in_off <= a_in_off;
    if (rst) b_item <= '0;
    else b_item <= b_next;
  end

  // Stage three: base of the tile in the pixel store.
  always_ff @(posedge clk) begin
    c_tprod  <= map_q * cfg.tile_area;
    c_in_off <= b_in_off;
    if (rst) c_item <= '0;
    else c_item <= b_item;
  end

  // Stage four: pixel store access.
  always_comb begin
    pix_off = PIX_OFF_W'(c_tprod) + PIX_OFF_W'(c_in_off);
    d_next  = c_item;
    if (c_item.status == ST_INSIDE && pix_off >= PIX_OFF_W'(PIXEL_STORE_DEPTH)) begin
      d_next.status = ST_FAULT;
    end
    pix_we = c_item.valid && c_item.mode == MODE_PIXEL &&
             (32'(c_item.wr_idx) < 32'(PIXEL_STORE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[PIX_AW'(32'(c_item.wr_idx))] <= c_item.wr_data[7:0];
    pix_q <= pix_mem[PIX_AW'(pix_off)];
    if (rst) d_item <= '0;
    else d_item <= d_next;
  end

  // Stage five: palette access.
  assign pal_we = d_item.valid && d_item.mode == MODE_PALETTE &&
                  (32'(d_item.wr_idx) < 32'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[PAL_AW'(32'(d_item.wr_idx))] <= d_item.wr_data;
    pal_q <= pal_mem[PAL_AW'(pix_q)];
    if (rst) e_item <= '0;
    else e_item <= d_item;
  end

  // Stage six: result register.
  always_ff @(posedge clk) begin
    color  <= (e_item.status == ST_INSIDE) ? pal_q : 32'h0000_0000;
    status <= e_item.status;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_item.valid && e_item.mode == MODE_QUERY;
    end
  end

endmodule

### design/tmpl_chk.sv
// Port-level checker of the tile map pixel lookup and its bind.
`timescale 1ns / 1ps
`include "tile_map_pixel_lookup_macros.svh"
module tmpl_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         mode,
  input logic               done,
  input logic [31:0]        color,
  input logic [1:0]         status
);
  import tmpl_pkg::*;

  `TMPL_ASSERT_LAT(a_query_done, start && !busy && mode == MODE_QUERY, LATENCY, done)
  `TMPL_ASSERT_IMP(a_done_from_query, done, $past(start && !busy && mode == MODE_QUERY, LATENCY))
  `TMPL_ASSERT_IMP(a_zero_on_miss, done && status != ST_INSIDE, color == 32'h0000_0000)
  `TMPL_ASSERT_IMP(a_status_code, done, status == ST_INSIDE || status == ST_OUTSIDE || status == ST_FAULT)

endmodule

bind tile_map_pixel_lookup tmpl_chk u_chk (.*);
